>>> hdl/lsfr_pkg.sv
// ----------------------------------------------------------------------------
// LIN slave frame receiver package
// Shared constants, types and helper functions for the receiver modules.
// ----------------------------------------------------------------------------
package lsfr_pkg;

  // Frame table geometry
  localparam int TABLE_ENTRIES = 8;    // entries looked up, indexes 0..7
  localparam int ENTRY_W       = 12;   // packed entry width
  localparam int CFG_W         = 48;   // one table register, four entries
  localparam int CFG_IDX_W     = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HIGH = 2'd1;

  // Bus constants
  localparam logic [7:0] SYNC_BYTE    = 8'h55;
  localparam logic [5:0] DIAG_REQ_ID  = 6'h3C;
  localparam logic [5:0] DIAG_RESP_ID = 6'h3D;
  localparam logic [3:0] DEFAULT_LEN  = 4'd8;

  // Receive phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PID  = 2'd1,
    PH_DATA = 2'd2,
    PH_CSUM = 2'd3
  } phase_e;

  // Table lookup outcome for one identifier
  typedef struct packed {
    logic [3:0] length;
    logic       enhanced;
  } lookup_t;

  // One completed frame
  typedef struct packed {
    logic [5:0]  frame_id;
    logic [7:0]  pid;
    logic [3:0]  length;
    logic [63:0] data;
    logic [7:0]  csum;
    logic        csum_ok;
  } result_t;

  // Protected identifier parity check
  function automatic logic pid_ok(logic [7:0] pid);
    logic p0;
    logic p1;
    p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
    p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
    return (pid[6] == p0) && (pid[7] == p1);
  endfunction

  // 8-bit add with end-around carry
  function automatic logic [7:0] add_carry(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

>>> hdl/lsfr_table.sv
// ----------------------------------------------------------------------------
// LIN frame table
// Holds the two table registers and matches an identifier against all
// entries in parallel; the lowest matching active entry wins.
// ----------------------------------------------------------------------------
module lsfr_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lsfr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [5:0]                     id_i,
  output lsfr_pkg::lookup_t              lookup_o
);
  import lsfr_pkg::*;

  logic [CFG_W-1:0] tbl_low_q;
  logic [CFG_W-1:0] tbl_high_q;
  logic [2*CFG_W-1:0] tbl_all;

  // Table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_low_q  <= '0;
      tbl_high_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_TABLE_LOW)  tbl_low_q  <= cfg_data_i;
      if (cfg_index_i == CFG_TABLE_HIGH) tbl_high_q <= cfg_data_i;
    end
  end

  assign tbl_all = {tbl_high_q, tbl_low_q};

  // Parallel match, scanned from the top so the lowest index wins
  always_comb begin
    logic [ENTRY_W-1:0] entry;
    lookup_o.length   = DEFAULT_LEN;
    lookup_o.enhanced = 1'b0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      entry = tbl_all[k*ENTRY_W +: ENTRY_W];
      if (entry[0] && (entry[6:1] == id_i)) begin
        lookup_o.length   = {1'b0, entry[9:7]} + 4'd1;
        lookup_o.enhanced = entry[10];
      end
    end
    // diagnostic frames always use the classic checksum
    if ((id_i == DIAG_REQ_ID) || (id_i == DIAG_RESP_ID)) lookup_o.enhanced = 1'b0;
  end

endmodule

>>> hdl/lsfr_rx.sv
// ----------------------------------------------------------------------------
// LIN frame receive sequencer
// Tracks the frame phase, collects data bytes, accumulates the checksum and
// forms the result at the checksum byte.
// ----------------------------------------------------------------------------
module lsfr_rx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  lsfr_pkg::lookup_t lookup_i,
  input  logic              out_stall_i,
  output logic              res_valid_o,
  output lsfr_pkg::result_t res_o
);
  import lsfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] pid_q, pid_d;
  logic [3:0] count_q, count_d;
  logic [3:0] exp_len_q, exp_len_d;
  logic       enh_q, enh_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] data_buf_q [8];
  logic       accept;
  logic       buf_we;
  logic [3:0] count_inc;
  logic [7:0] calc;

  // Only the checksum byte produces a result, so only it waits on the output
  assign rx_ready_o = (phase_q != PH_CSUM) || !out_stall_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign count_inc  = count_q + 4'd1;
  assign calc       = ~sum_q;

  // Next state and results
  always_comb begin
    phase_d     = phase_q;
    pid_d       = pid_q;
    count_d     = count_q;
    exp_len_d   = exp_len_q;
    enh_d       = enh_q;
    sum_d       = sum_q;
    buf_we      = 1'b0;
    res_valid_o = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == SYNC_BYTE) phase_d = PH_PID;
        end
        PH_PID: begin
          pid_d   = rx_byte_i;
          count_d = '0;
          if (!pid_ok(rx_byte_i)) begin
            phase_d = PH_IDLE;
          end else begin
            exp_len_d = lookup_i.length;
            enh_d     = lookup_i.enhanced;
            sum_d     = lookup_i.enhanced ? rx_byte_i : 8'd0;
            phase_d   = PH_DATA;
          end
        end
        PH_DATA: begin
          buf_we  = 1'b1;
          count_d = count_inc;
          sum_d   = add_carry(sum_q, rx_byte_i);
          if (count_inc >= exp_len_q) phase_d = PH_CSUM;
        end
        PH_CSUM: begin
          res_valid_o = 1'b1;
          phase_d     = PH_IDLE;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Result fields; bytes beyond the received count read as zero
  always_comb begin
    res_o.frame_id = pid_q[5:0];
    res_o.pid      = pid_q;
    res_o.length   = count_q;
    res_o.csum     = rx_byte_i;
    res_o.csum_ok  = (rx_byte_i == calc);
    for (int i = 0; i < 8; i++) begin
      res_o.data[8*i +: 8] = (4'(i) < count_q) ? data_buf_q[i] : 8'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pid_q     <= '0;
      count_q   <= '0;
      exp_len_q <= '0;
      enh_q     <= 1'b0;
      sum_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      pid_q     <= pid_d;
      count_q   <= count_d;
      exp_len_q <= exp_len_d;
      enh_q     <= enh_d;
      sum_q     <= sum_d;
    end
  end

  // Data byte buffer, no reset
  always_ff @(posedge clk_i) begin
    if (buf_we) data_buf_q[count_q[2:0]] <= rx_byte_i;
  end

endmodule

>>> hdl/lsfr_out.sv
// ----------------------------------------------------------------------------
// LIN frame result register
// Holds one completed frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module lsfr_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lsfr_pkg::result_t res_i,
  output logic              stall_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output lsfr_pkg::result_t res_o
);
  import lsfr_pkg::*;

  logic    valid_q;
  result_t res_q;

  // result held and not taken this cycle
  assign stall_o     = valid_q && !res_ready_i;
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

endmodule

>>> hdl/lin_slave_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// LIN slave frame receiver
// Receives LIN bus bytes and reports each completed frame.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the rx channel (valid/ready), one transfer per byte. Idle
//   bytes other than the sync byte are dropped; then come the protected
//   identifier, the data bytes and the checksum byte. A bad identifier
//   parity drops the frame silently.
//   The frame table (two 48-bit registers) is written through cfg_we_i /
//   cfg_index_i / cfg_data_i; the user must write it only while no frame
//   is in progress; the block does not enforce this. Throughput: one byte
//   per cycle outside a stall. The table match and checksum update are
//   combinational between the phase registers. The frame result is visible
//   on the res channel the cycle after the checksum byte is transferred,
//   and stays until res_ready_i is high. Stall: only a checksum byte waits
//   while an earlier result is still held; all other bytes keep flowing.
//   Reset: returns to idle, clears the frame table and drops any held result.
// ----------------------------------------------------------------------------
module lin_slave_frame_receiver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lsfr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           rx_valid_i,
  output logic                           rx_ready_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [5:0]                     frame_id_o,
  output logic [7:0]                     protected_id_byte_o,
  output logic [3:0]                     data_length_o,
  output logic [63:0]                    frame_data_o,
  output logic [7:0]                     received_checksum_o,
  output logic                           checksum_ok_o
);
  import lsfr_pkg::*;

  lookup_t lookup;
  result_t rx_res;
  result_t out_res;
  logic    rx_res_valid;
  logic    out_stall;

  // Frame table
  lsfr_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .id_i        (rx_byte_i[5:0]),
    .lookup_o    (lookup)
  );

  // Receive sequencer
  lsfr_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .lookup_i    (lookup),
    .out_stall_i (out_stall),
    .res_valid_o (rx_res_valid),
    .res_o       (rx_res)
  );

  // Result register
  lsfr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (rx_res_valid),
    .res_i       (rx_res),
    .stall_o     (out_stall),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_o       (out_res)
  );

  assign frame_id_o          = out_res.frame_id;
  assign protected_id_byte_o = out_res.pid;
  assign data_length_o       = out_res.length;
  assign frame_data_o        = out_res.data;
  assign received_checksum_o = out_res.csum;
  assign checksum_ok_o       = out_res.csum_ok;

endmodule
